// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, codes and constants of the text console character writer.
`default_nettype none
package tcw_pkg;

    // Field widths of the stream payloads
    localparam int OP_W     = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int OUTCOL_W = 7;
    localparam int OUTROW_W = 5;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = 16;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ATTR_W-1:0] attr_t;
    typedef logic [CELL_W-1:0] cell_t;

    // Operation codes
    localparam op_t OP_PUT   = 2'd0;
    localparam op_t OP_CLEAR = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    // Character codes and attributes
    localparam char_t CH_NEWLINE   = 8'd10;
    localparam char_t CH_BACKSPACE = 8'd8;
    localparam char_t CH_SPACE     = 8'd32;
    localparam attr_t CLEAR_ATTR   = 8'h07;

    // Glyph in the low byte, attribute in the high byte
    function automatic cell_t make_cell(input char_t glyph, input attr_t attr);
        make_cell = {attr, glyph};
    endfunction

    localparam cell_t BLANK_CELL = {CLEAR_ATTR, CH_SPACE};

endpackage : tcw_pkg
`default_nettype wire

// ===== hw/rtl/text_console_char_writer_core.sv =====
// Top level of the text console character writer: sequencer, cursor and stream ports.
`default_nettype none
// A character-cell text console of COLUMNS x ROWS 16-bit cells (glyph in the low byte,
// attribute in the high byte) with a cursor. One item is taken at a time; s_tready is low
// while an item is at work. A character, newline or backspace passes through the calculate
// state and an in-range read of one cell through the read wait state, each then through the
// done state; an unused op or a read past the last cell goes straight to the done state.
// A newline or wrap on the last row scrolls: the sweep pointer moves each cell through
// the read port and the write port of the screen store, a read state then a write state
// for each cell, then blanks the bottom row at one cell a cycle. Clear screen writes one cell
// a cycle. After reset a clearing pass fills the store with blanks before the first input
// is taken; configuration writes are taken at any time. A finished result waits in the
// output register and does not block the next transfer in.
module text_console_char_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration: text_attribute
    input  wire logic                  cfg_we,
    input  wire tcw_pkg::attr_t        cfg_wdata,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // char_code[7:0], cell_index[18:8], zeros
    input  wire tcw_pkg::op_t          s_tuser,   // op[1:0]
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata    // cursor_column[6:0], cursor_line[11:7],
                                                  // cell_value[27:12], zeros
);
    import tcw_pkg::*;

    localparam int CELLS     = COLUMNS * ROWS;
    localparam int AW        = $clog2(CELLS);
    localparam int CW        = $clog2(COLUMNS);
    localparam int RW        = $clog2(ROWS);
    localparam int LAST_MOVE = CELLS - COLUMNS - 1;

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CALC   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_SCR_RD = 3'd4;
    localparam logic [2:0] ST_SCR_WR = 3'd5;
    localparam logic [2:0] ST_BLANK  = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [RW-1:0]       row_reg, row_next;
    logic                clr_result_reg, clr_result_next;
    attr_t               attr_reg;
    char_t               char_reg, char_next;
    cell_t               cell_reg, cell_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_data_reg, m_data_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    cell_t               ram_wdata;
    logic [AW-1:0]       ram_raddr;
    cell_t               ram_rdata;

    op_t                 in_op;
    char_t               in_char;
    logic [INDEX_W-1:0]  in_index;
    logic                in_xfer;
    logic                idx_in_range;
    logic [CW-1:0]       bs_col;
    logic [RW-1:0]       bs_row;
    logic                col_last;
    logic                row_last;
    logic                out_free;

    assign in_op    = s_tuser;
    assign in_char  = s_tdata[7:0];
    assign in_index = s_tdata[18:8];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign idx_in_range = (32'(in_index) < 32'(CELLS));
    assign col_last = (32'(col_reg) == 32'(COLUMNS - 1));
    assign row_last = (32'(row_reg) == 32'(ROWS - 1));
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Step back one cell, wrapping to the end of the previous row; hold at home
    always_comb begin
        bs_col = col_reg;
        bs_row = row_reg;
        if (col_reg != '0) begin
            bs_col = col_reg - 1'b1;
        end else if (row_reg != '0) begin
            bs_row = row_reg - 1'b1;
            bs_col = CW'(COLUMNS - 1);
        end
    end

    // Sequencer, cursor and screen store port control
    always_comb begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        clr_result_next = clr_result_reg;
        char_next       = char_reg;
        cell_next       = cell_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = BLANK_CELL;
        ram_raddr       = AW'(in_index);

        // Drop the result once it is taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = BLANK_CELL;
                ptr_next  = ptr_reg + 1'b1;
                if (32'(ptr_reg) == 32'(CELLS - 1)) begin
                    ptr_next   = '0;
                    state_next = clr_result_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    char_next = in_char;
                    cell_next = '0;
                    case (in_op)
                        OP_PUT: begin
                            state_next = ST_CALC;
                        end
                        OP_CLEAR: begin
                            col_next        = '0;
                            row_next        = '0;
                            ptr_next        = '0;
                            clr_result_next = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        OP_READ: begin
                            state_next = idx_in_range ? ST_READ : ST_DONE;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CALC: begin
                state_next = ST_DONE;
                if (char_reg == CH_NEWLINE) begin
                    col_next = '0;
                    if (!row_last) begin
                        row_next = row_reg + 1'b1;
                    end else begin
                        ptr_next   = '0;
                        state_next = ST_SCR_RD;
                    end
                end else if (char_reg == CH_BACKSPACE) begin
                    col_next  = bs_col;
                    row_next  = bs_row;
                    ram_we    = 1'b1;
                    ram_waddr = AW'(32'(bs_row) * COLUMNS + 32'(bs_col));
                    ram_wdata = make_cell(CH_SPACE, attr_reg);
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
                    ram_wdata = make_cell(char_reg, attr_reg);
                    if (!col_last) begin
                        col_next = col_reg + 1'b1;
                    end else begin
                        col_next = '0;
                        if (!row_last) begin
                            row_next = row_reg + 1'b1;
                        end else begin
                            ptr_next   = '0;
                            state_next = ST_SCR_RD;
                        end
                    end
                end
            end
            ST_READ: begin
                cell_next  = ram_rdata;
                state_next = ST_DONE;
            end
            ST_SCR_RD: begin
                ram_raddr  = AW'(32'(ptr_reg) + COLUMNS);
                state_next = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_reg + 1'b1;
                state_next = (32'(ptr_reg) == 32'(LAST_MOVE)) ? ST_BLANK : ST_SCR_RD;
            end
            ST_BLANK: begin
                ram_we    = 1'b1;
                ram_wdata = make_cell(CH_SPACE, attr_reg);
                ptr_next  = ptr_reg + 1'b1;
                if (32'(ptr_reg) == 32'(CELLS - 1)) begin
                    ptr_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold until the output register is free, then load the result
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = {4'd0, cell_reg, OUTROW_W'(row_reg),
                                       OUTCOL_W'(col_reg)};
                    clr_result_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            ptr_reg        <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            clr_result_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ptr_reg        <= ptr_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            clr_result_reg <= clr_result_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Attribute register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= CLEAR_ATTR;
        end else if (cfg_we) begin
            attr_reg <= cfg_wdata;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        char_reg   <= char_next;
        cell_reg   <= cell_next;
        m_data_reg <= m_data_next;
    end

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Cursor stays on the screen
    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(col_reg) < 32'(COLUMNS)) && (32'(row_reg) < 32'(ROWS)))
        else $error("cursor left the screen");

    // Every screen store write lands inside the store
    a_write_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (32'(ram_waddr) < 32'(CELLS)))
        else $error("screen store write out of range");

    // An in-range read goes through the read wait state
    a_read_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (in_op == OP_READ) && idx_in_range) |=> (state_reg == ST_READ))
        else $error("read did not wait for store data");

    // A transfer in closes the input until its result is loaded
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> !s_tready)
        else $error("input taken while an item is at work");

endmodule : text_console_char_writer_core
`default_nettype wire

// ===== hw/rtl/tcw_screen_ram.sv =====
// Screen store: one write port and one registered read port.
`default_nettype none
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire tcw_pkg::cell_t     wr_data,
    input  wire logic [AW-1:0]      rd_addr,
    output tcw_pkg::cell_t          rd_data
);
    import tcw_pkg::*;

    cell_t mem [DEPTH];

    // Write the addressed cell
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule : tcw_screen_ram
`default_nettype wire
